[rtl/grid_dda_wall_raycast_core_assert.svh]
// assertion macros for the ray caster back end
`ifndef GRID_DDA_WALL_RAYCAST_CORE_ASSERT_SVH
`define GRID_DDA_WALL_RAYCAST_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define GDR_ASSERT_IMP(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define GDR_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/gdr_pkg.sv]
// types and constants shared by the ray caster modules
`timescale 1ns / 1ps
package gdr_pkg;

    localparam int RAY_W      = 24;
    localparam int DX_W       = 18;
    localparam int SPAN_W     = 12;
    localparam int PROD_W     = 28;
    localparam int DIVIDEND_W = 42;
    localparam int DIVISOR_W  = 24;
    localparam int LH_W       = 25;
    localparam int ROW_W      = 27;
    localparam int ONE_Q10    = 1024;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_CAST  = 1'b1;

    localparam logic STATUS_HIT   = 1'b0;
    localparam logic STATUS_NOHIT = 1'b1;

    localparam logic SIDE_X = 1'b0;
    localparam logic SIDE_Y = 1'b1;

    localparam logic [2:0] CFG_CAMERA_X      = 3'd0;
    localparam logic [2:0] CFG_CAMERA_Y      = 3'd1;
    localparam logic [2:0] CFG_VIEW_DIR_X    = 3'd2;
    localparam logic [2:0] CFG_VIEW_DIR_Y    = 3'd3;
    localparam logic [2:0] CFG_CAM_PLANE_X   = 3'd4;
    localparam logic [2:0] CFG_CAM_PLANE_Y   = 3'd5;
    localparam logic [2:0] CFG_HORIZON_SHIFT = 3'd6;
    localparam logic [2:0] CFG_TEXTURE_WIDTH = 3'd7;

    typedef struct packed {
        logic [14:0]        camera_x;
        logic [14:0]        camera_y;
        logic signed [15:0] view_dir_x;
        logic signed [15:0] view_dir_y;
        logic signed [15:0] cam_plane_x;
        logic signed [15:0] cam_plane_y;
        logic signed [7:0]  horizon_shift;
        logic [6:0]         texture_width;
    } cfg_t;

    typedef struct packed {
        logic       mode;
        logic [8:0] column;
        logic [9:0] cell_index;
        logic [3:0] cell_value;
    } item_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_stat_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
        logic [DIVISOR_W-1:0]  remainder;
    } div_rsp_t;

    typedef struct packed {
        logic [8:0]  out_column;
        logic        hit_status;
        logic        hit_side;
        logic [3:0]  wall_type;
        logic [15:0] wall_distance;
        logic [7:0]  span_start;
        logic [7:0]  span_end;
        logic [5:0]  texture_column;
    } result_t;

endpackage

[rtl/grid_dda_wall_raycast_core.sv]
// a map write goes into the map memory when popped; a cast runs the ray setup states,
// S_STEP and S_CHECK per grid step (up to 2*MAP_SIDE steps) and up to three divisions
// throughput: one word at a time in the back end, set by the shared serial divider
// and the walk loop reading the map memory each step; a two-word queue buffers intake
// reset: asynchronous active low; then a map clearing pass over all MAP_SIDE*MAP_SIDE
// cells runs with s_tready low, config writes still taken
`timescale 1ns / 1ps
module grid_dda_wall_raycast_core #(
    parameter int SCREEN_COLUMNS = 400,
    parameter int SCREEN_ROWS    = 240,
    parameter int MAP_SIDE       = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // column, cell_index, cell_value
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_column, hit_side, wall_type, wall_distance,
                                   // span_start, span_end, texture_column
    output logic        m_tuser    // hit_status
);
    import gdr_pkg::*;

    cfg_t     cfg;
    q_stat_t  q_stat;
    item_t    push_item;
    item_t    head;
    logic     push;
    logic     pop;
    logic     clearing;
    div_req_t div_req;
    div_rsp_t div_rsp;
    result_t  res;

    gdr_front #(.MAP_SIDE(MAP_SIDE)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .cfg          (cfg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_mode       (s_tuser),
        .s_column     (s_tdata[8:0]),
        .s_cell_index (s_tdata[18:9]),
        .s_cell_value (s_tdata[22:19]),
        .clearing     (clearing),
        .q_stat       (q_stat),
        .push         (push),
        .push_item    (push_item)
    );

    gdr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    gdr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    gdr_back #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS),
        .MAP_SIDE       (MAP_SIDE)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_stat   (q_stat),
        .head     (head),
        .pop      (pop),
        .clearing (clearing),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (res)
    );

    assign m_tuser = res.hit_status;
    assign m_tdata = {4'd0, res.texture_column, res.span_end, res.span_start,
                      res.wall_distance, res.wall_type, res.hit_side, res.out_column};

endmodule

[rtl/gdr_front.sv]
// front end: config registers, word intake and classification
`timescale 1ns / 1ps
module gdr_front #(
    parameter int MAP_SIDE = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [2:0]     cfg_index,
    input  logic [15:0]    cfg_wdata,
    output gdr_pkg::cfg_t  cfg,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic           s_mode,
    input  logic [8:0]     s_column,
    input  logic [9:0]     s_cell_index,
    input  logic [3:0]     s_cell_value,
    input  logic           clearing,
    input  gdr_pkg::q_stat_t q_stat,
    output logic           push,
    output gdr_pkg::item_t push_item
);
    import gdr_pkg::*;

    localparam int CELL_COUNT = MAP_SIDE * MAP_SIDE;

    cfg_t cfg_reg;
    logic keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.camera_x      <= 15'd2048;
            cfg_reg.camera_y      <= 15'd2048;
            cfg_reg.view_dir_x    <= -16'sd16384;
            cfg_reg.view_dir_y    <= 16'sd0;
            cfg_reg.cam_plane_x   <= 16'sd0;
            cfg_reg.cam_plane_y   <= 16'sd10813;
            cfg_reg.horizon_shift <= 8'sd0;
            cfg_reg.texture_width <= 7'd32;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CAMERA_X:      cfg_reg.camera_x      <= cfg_wdata[14:0];
                CFG_CAMERA_Y:      cfg_reg.camera_y      <= cfg_wdata[14:0];
                CFG_VIEW_DIR_X:    cfg_reg.view_dir_x    <= $signed(cfg_wdata);
                CFG_VIEW_DIR_Y:    cfg_reg.view_dir_y    <= $signed(cfg_wdata);
                CFG_CAM_PLANE_X:   cfg_reg.cam_plane_x   <= $signed(cfg_wdata);
                CFG_CAM_PLANE_Y:   cfg_reg.cam_plane_y   <= $signed(cfg_wdata);
                CFG_HORIZON_SHIFT: cfg_reg.horizon_shift <= $signed(cfg_wdata[7:0]);
                CFG_TEXTURE_WIDTH: cfg_reg.texture_width <= cfg_wdata[6:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

    // writes beyond the map are taken and dropped
    assign keep = (s_mode == MODE_CAST) || (32'(s_cell_index) < 32'(CELL_COUNT));

    assign s_tready             = !q_stat.full && !clearing;
    assign push                 = s_tvalid && s_tready && keep;
    assign push_item.mode       = s_mode;
    assign push_item.column     = s_column;
    assign push_item.cell_index = s_cell_index;
    assign push_item.cell_value = s_cell_value;

endmodule

[rtl/gdr_queue.sv]
// two-entry queue between front and back
`timescale 1ns / 1ps
module gdr_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  gdr_pkg::item_t   push_item,
    input  logic             pop,
    output gdr_pkg::item_t   head,
    output gdr_pkg::q_stat_t q_stat
);
    import gdr_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign q_stat.valid = count_reg != 2'd0;
    assign q_stat.full  = count_reg == 2'd2;

endmodule

[rtl/gdr_div.sv]
// shared radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module gdr_div (
    input  logic              clk,
    input  logic              rst_n,
    input  gdr_pkg::div_req_t req,
    output gdr_pkg::div_rsp_t rsp
);
    import gdr_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quot_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    assign trial = {rem_reg, quot_reg[DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quot_reg    <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? DIVISOR_W'(trial - {1'b0, divisor_reg})
                             : trial[DIVISOR_W-1:0];
            quot_reg <= {quot_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quot_reg;
    assign rsp.remainder = rem_reg;

endmodule

[rtl/gdr_back.sv]
// back end: map memory, ray setup, grid walk and result register
`timescale 1ns / 1ps
`include "grid_dda_wall_raycast_core_assert.svh"
module gdr_back #(
    parameter int SCREEN_COLUMNS = 400,
    parameter int SCREEN_ROWS    = 240,
    parameter int MAP_SIDE       = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  gdr_pkg::cfg_t     cfg,
    input  gdr_pkg::q_stat_t  q_stat,
    input  gdr_pkg::item_t    head,
    output logic              pop,
    output logic              clearing,
    output gdr_pkg::div_req_t div_req,
    input  gdr_pkg::div_rsp_t div_rsp,
    output logic              m_valid,
    input  logic              m_ready,
    output gdr_pkg::result_t  m_result
);
    import gdr_pkg::*;

    localparam int CELL_COUNT = MAP_SIDE * MAP_SIDE;
    localparam int AW   = $clog2(CELL_COUNT);
    localparam int MW   = $clog2(MAP_SIDE);
    localparam int CW   = $clog2(2 * MAP_SIDE + 32) + 1;
    localparam int SW   = $clog2(2 * MAP_SIDE + 1);
    localparam int CLRW = $clog2(CELL_COUNT + 1);

    // reciprocal of the column count, exact for plane products below 2^25
    localparam int     RECIP_K = 25 + $clog2(SCREEN_COLUMNS);
    localparam int     RECIP_W = 27;
    localparam longint RECIP_M = ((longint'(1) << RECIP_K) + longint'(SCREEN_COLUMNS) - 1)
                               / longint'(SCREEN_COLUMNS);

    typedef enum logic [3:0] {
        S_IDLE, S_RX, S_RY, S_RYQ, S_INIT, S_STEP, S_CHECK, S_DIST,
        S_DISTW, S_COORDW, S_LH, S_LHW, S_FIN
    } state_t;

    state_t state_reg;

    logic [3:0] mem [CELL_COUNT];
    logic [3:0] rdata_reg;
    logic       mem_we;
    logic [AW-1:0] mem_wa;
    logic [3:0] mem_wd;
    logic [AW-1:0] rd_addr;

    logic [CLRW-1:0] clr_cnt_reg;
    logic [8:0]      col_reg;
    logic            neg_reg;
    logic [PROD_W-1:0] prod_abs_reg;
    logic signed [RAY_W-1:0] rx_reg;
    logic signed [RAY_W-1:0] ry_reg;
    logic [DX_W-1:0] dx_reg;
    logic [DX_W-1:0] dy_reg;
    logic signed [CW-1:0] mx_reg;
    logic signed [CW-1:0] my_reg;
    logic [SW-1:0] step_reg;
    logic          side_reg;
    logic          inmap_reg;
    logic          nohit_reg;
    logic [3:0]    wall_reg;
    logic [15:0]   dist_reg;
    logic [9:0]    frac_reg;
    logic [LH_W-1:0] lh_reg;
    logic          out_valid_reg;
    result_t       out_reg;

    // ray setup
    logic [8:0]               span_col;
    logic signed [SPAN_W-1:0] span;
    logic signed [15:0]       plane_sel;
    logic signed [PROD_W-1:0] plane_prod;
    logic [PROD_W-1:0]        plane_abs;
    logic [PROD_W+RECIP_W-1:0] recip_prod;
    logic [RAY_W-1:0]         quot_ray;
    logic signed [RAY_W-1:0]  ray_new;
    logic signed [15:0]       dir_sel;

    // walk
    logic [RAY_W-1:0] ax;
    logic [RAY_W-1:0] ay;
    logic [DX_W+RAY_W-1:0] prod_a;
    logic [DX_W+RAY_W-1:0] prod_b;
    logic xstep;
    logic signed [CW-1:0] mx_step;
    logic signed [CW-1:0] my_step;
    logic inmap;

    // hit math
    logic [DX_W-1:0]  d_sel;
    logic [DX_W-1:0]  d_off;
    logic [RAY_W-1:0] a_sel;
    logic signed [RAY_W-1:0] r_other;
    logic [RAY_W-1:0] r_other_abs;
    logic [14:0]      p_sel;
    logic [9:0]       qa10;
    logic [9:0]       fq10;

    // finish
    logic signed [ROW_W-1:0] center;
    logic signed [ROW_W-1:0] half;
    logic [6:0]  tw;
    logic [16:0] tex_prod;
    logic [6:0]  tex_raw;
    logic [6:0]  tex_fin;
    logic        mirror;
    logic        out_free;

    function automatic logic [7:0] clip_row(input logic signed [ROW_W-1:0] r);
        logic [7:0] v;
        if (r < 0)
        begin
            v = 8'd0;
        end
        else if (r > ROW_W'(SCREEN_ROWS - 1))
        begin
            v = 8'(SCREEN_ROWS - 1);
        end
        else
        begin
            v = r[7:0];
        end
        return v;
    endfunction

    assign clearing = 32'(clr_cnt_reg) < 32'(CELL_COUNT);
    assign out_free = !out_valid_reg || m_ready;
    assign pop      = (state_reg == S_IDLE) && !clearing && q_stat.valid;

    assign span_col   = col_reg;
    assign span       = $signed({2'b00, span_col, 1'b0}) - SPAN_W'(SCREEN_COLUMNS);
    assign plane_sel  = (state_reg == S_RX) ? cfg.cam_plane_x : cfg.cam_plane_y;
    assign plane_prod = plane_sel * span;
    assign plane_abs  = plane_prod[PROD_W-1] ? PROD_W'(-plane_prod) : PROD_W'(plane_prod);
    assign recip_prod = prod_abs_reg * RECIP_W'(RECIP_M);
    assign dir_sel    = (state_reg == S_RY) ? cfg.view_dir_x : cfg.view_dir_y;
    assign quot_ray   = RAY_W'(recip_prod >> RECIP_K);
    assign ray_new    = RAY_W'(dir_sel)
                      + (neg_reg ? -$signed(quot_ray) : $signed(quot_ray));

    assign ax = rx_reg[RAY_W-1] ? RAY_W'(-rx_reg) : RAY_W'(rx_reg);
    assign ay = ry_reg[RAY_W-1] ? RAY_W'(-ry_reg) : RAY_W'(ry_reg);
    assign prod_a = dx_reg * ay;
    assign prod_b = dy_reg * ax;
    assign xstep  = prod_a < prod_b;
    assign mx_step = !xstep ? mx_reg : (rx_reg[RAY_W-1] ? mx_reg - CW'(1) : mx_reg + CW'(1));
    assign my_step = xstep ? my_reg : (ry_reg[RAY_W-1] ? my_reg - CW'(1) : my_reg + CW'(1));
    assign inmap = (mx_step >= 0) && (mx_step < $signed(CW'(MAP_SIDE)))
                && (my_step >= 0) && (my_step < $signed(CW'(MAP_SIDE)));
    assign rd_addr = AW'(int'(my_step[MW-1:0]) * MAP_SIDE + int'(mx_step[MW-1:0]));

    assign d_sel       = side_reg ? dy_reg : dx_reg;
    assign d_off       = d_sel - DX_W'(ONE_Q10);
    assign a_sel       = side_reg ? ay : ax;
    assign r_other     = side_reg ? rx_reg : ry_reg;
    assign r_other_abs = side_reg ? ax : ay;
    assign p_sel       = side_reg ? cfg.camera_x : cfg.camera_y;
    assign qa10        = div_rsp.quotient[9:0];
    assign fq10        = neg_reg ? 10'(-(qa10 + 10'(div_rsp.remainder != '0))) : qa10;

    assign center = ROW_W'(SCREEN_ROWS / 2) + ROW_W'(cfg.horizon_shift);
    assign half   = $signed({2'b00, lh_reg[LH_W-1:1]});
    assign tw     = (cfg.texture_width == 7'd0) ? 7'd1
                  : ((cfg.texture_width > 7'd64) ? 7'd64 : cfg.texture_width);
    assign tex_prod = frac_reg * tw;
    assign tex_raw  = tex_prod[16:10];
    assign mirror   = ((side_reg == SIDE_X) && !rx_reg[RAY_W-1] && (rx_reg != '0))
                   || ((side_reg == SIDE_Y) && ry_reg[RAY_W-1]);
    assign tex_fin  = mirror ? 7'(tw - tex_raw - 7'd1) : tex_raw;

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = AW'(clr_cnt_reg);
        mem_wd = 4'd0;
        if (clearing)
        begin
            mem_we = 1'b1;
        end
        else if (pop && (head.mode == MODE_WRITE))
        begin
            mem_we = 1'b1;
            mem_wa = AW'(head.cell_index);
            mem_wd = head.cell_value;
        end
    end

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        case (state_reg)
            S_DIST:
            begin
                div_req.start    = a_sel != '0;
                div_req.dividend = DIVIDEND_W'({d_off, 14'd0});
                div_req.divisor  = a_sel;
            end
            S_DISTW:
            begin
                div_req.start    = div_rsp.done;
                div_req.dividend = d_off * r_other_abs;
                div_req.divisor  = a_sel;
            end
            S_LH:
            begin
                div_req.start    = dist_reg != 16'd0;
                div_req.dividend = DIVIDEND_W'(SCREEN_ROWS * ONE_Q10);
                div_req.divisor  = DIVISOR_W'(dist_reg);
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if ((state_reg == S_FIN) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (pop && (head.mode == MODE_CAST))
                    begin
                        col_reg   <= head.column;
                        state_reg <= S_RX;
                    end
                end
                S_RX:
                begin
                    prod_abs_reg <= plane_abs;
                    neg_reg      <= plane_prod[PROD_W-1];
                    state_reg    <= S_RY;
                end
                S_RY:
                begin
                    rx_reg       <= ray_new;
                    prod_abs_reg <= plane_abs;
                    neg_reg      <= plane_prod[PROD_W-1];
                    state_reg    <= S_RYQ;
                end
                S_RYQ:
                begin
                    ry_reg    <= ray_new;
                    state_reg <= S_INIT;
                end
                S_INIT:
                begin
                    mx_reg    <= CW'(cfg.camera_x[14:10]);
                    my_reg    <= CW'(cfg.camera_y[14:10]);
                    dx_reg    <= rx_reg[RAY_W-1] ? DX_W'(cfg.camera_x[9:0])
                                               : DX_W'(ONE_Q10) - DX_W'(cfg.camera_x[9:0]);
                    dy_reg    <= ry_reg[RAY_W-1] ? DX_W'(cfg.camera_y[9:0])
                                               : DX_W'(ONE_Q10) - DX_W'(cfg.camera_y[9:0]);
                    step_reg  <= '0;
                    state_reg <= S_STEP;
                end
                S_STEP:
                begin
                    mx_reg    <= mx_step;
                    my_reg    <= my_step;
                    side_reg  <= xstep ? SIDE_X : SIDE_Y;
                    if (xstep)
                    begin
                        dx_reg <= dx_reg + DX_W'(ONE_Q10);
                    end
                    else
                    begin
                        dy_reg <= dy_reg + DX_W'(ONE_Q10);
                    end
                    inmap_reg <= inmap;
                    step_reg  <= step_reg + 1'b1;
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (inmap_reg && (rdata_reg != 4'd0))
                    begin
                        wall_reg  <= rdata_reg;
                        nohit_reg <= 1'b0;
                        state_reg <= S_DIST;
                    end
                    else if (32'(step_reg) == 32'(2 * MAP_SIDE))
                    begin
                        nohit_reg <= 1'b1;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_STEP;
                    end
                end
                S_DIST:
                begin
                    if (a_sel == '0)
                    begin
                        dist_reg  <= 16'hFFFF;
                        frac_reg  <= p_sel[9:0];
                        state_reg <= S_LH;
                    end
                    else
                    begin
                        state_reg <= S_DISTW;
                    end
                end
                S_DISTW:
                begin
                    if (div_rsp.done)
                    begin
                        dist_reg  <= (div_rsp.quotient[DIVIDEND_W-1:16] != '0) ? 16'hFFFF
                                                                 : div_rsp.quotient[15:0];
                        neg_reg   <= r_other[RAY_W-1];
                        state_reg <= S_COORDW;
                    end
                end
                S_COORDW:
                begin
                    if (div_rsp.done)
                    begin
                        frac_reg  <= p_sel[9:0] + fq10;
                        state_reg <= S_LH;
                    end
                end
                S_LH:
                begin
                    if (dist_reg == 16'd0)
                    begin
                        lh_reg    <= LH_W'(1 << 24);
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_LHW;
                    end
                end
                S_LHW:
                begin
                    if (div_rsp.done)
                    begin
                        lh_reg    <= div_rsp.quotient[LH_W-1:0];
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_reg.out_column <= col_reg;
                        if (nohit_reg)
                        begin
                            out_reg.hit_status     <= STATUS_NOHIT;
                            out_reg.hit_side       <= SIDE_X;
                            out_reg.wall_type      <= 4'd0;
                            out_reg.wall_distance  <= 16'hFFFF;
                            out_reg.span_start     <= 8'd0;
                            out_reg.span_end       <= 8'd0;
                            out_reg.texture_column <= 6'd0;
                        end
                        else
                        begin
                            out_reg.hit_status     <= STATUS_HIT;
                            out_reg.hit_side       <= side_reg;
                            out_reg.wall_type      <= wall_reg;
                            out_reg.wall_distance  <= dist_reg;
                            out_reg.span_start     <= clip_row(center - half);
                            out_reg.span_end       <= clip_row(center + half);
                            out_reg.texture_column <= tex_fin[5:0];
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    `GDR_ASSERT_IMP(a_div_start_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")
    `GDR_ASSERT_NEXT(a_step_then_check, state_reg == S_STEP, state_reg == S_CHECK, "walk skipped check")
    `GDR_ASSERT_IMP(a_no_pop_clearing, clearing, !pop, "queue popped during map clear")
    `GDR_ASSERT_IMP(a_nohit_fields, m_valid && (m_result.hit_status == STATUS_NOHIT), (m_result.wall_type == 4'd0) && (m_result.wall_distance == 16'hFFFF), "no-hit word carries wall data")

endmodule

[tb/tb_grid_dda_wall_raycast_core.sv]
// testbench for the grid ray caster: map writes and column casts checked against a predictor
`timescale 1ns / 1ps
module tb_grid_dda_wall_raycast_core;
    import gdr_pkg::*;

    localparam int COLS     = 400;
    localparam int ROWS     = 240;
    localparam int SIDE     = 32;
    localparam int WDOG_MAX = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tuser;

    cfg_t      cam;
    logic [3:0] map_model [SIDE*SIDE];
    item_t     pending [$];
    result_t   column_results [$];
    item_t     cur_word;
    int        gap_max;
    int        stall_max;
    int        errors;
    int        casts_seen;
    int        writes_seen;
    int        nohits_seen;
    int        idle_cycles;

    grid_dda_wall_raycast_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic longint floor_quot(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint clip_row(longint r);
        if (r < 0)
            return 0;
        if (r > ROWS - 1)
            return ROWS - 1;
        return r;
    endfunction

    function automatic result_t cast_column(logic [8:0] col);
        longint px, py, spn, rx, ry, ax, ay, mx, my, dx, dy, stx, sty;
        longint wdist, lh, coord, half, s0, s1, tw, tex, fr;
        int side;
        bit hit;
        result_t r;
        px   = cam.camera_x;
        py   = cam.camera_y;
        spn  = 2 * longint'(col) - COLS;
        rx   = longint'($signed(cam.view_dir_x)) + (longint'($signed(cam.cam_plane_x)) * spn) / COLS;
        ry   = longint'($signed(cam.view_dir_y)) + (longint'($signed(cam.cam_plane_y)) * spn) / COLS;
        ax   = rx < 0 ? -rx : rx;
        ay   = ry < 0 ? -ry : ry;
        mx   = px >>> 10;
        my   = py >>> 10;
        stx  = rx < 0 ? -1 : 1;
        sty  = ry < 0 ? -1 : 1;
        dx   = rx < 0 ? (px % 1024) : ONE_Q10 - (px % 1024);
        dy   = ry < 0 ? (py % 1024) : ONE_Q10 - (py % 1024);
        side = 0;
        hit  = 0;
        r    = '0;
        for (int s = 0; s < 2 * SIDE; s++)
        begin
            if (dx * ay < dy * ax)
            begin
                mx = mx + stx; dx = dx + ONE_Q10; side = 0;
            end
            else
            begin
                my = my + sty; dy = dy + ONE_Q10; side = 1;
            end
            if (mx >= 0 && mx < SIDE && my >= 0 && my < SIDE && map_model[my * SIDE + mx] != 0)
            begin
                hit = 1;
                break;
            end
        end
        r.out_column = col;
        if (!hit)
        begin
            r.hit_status    = STATUS_NOHIT;
            r.hit_side      = SIDE_X;
            r.wall_distance = 16'hFFFF;
            return r;
        end
        if (side == 0)
        begin
            if (ax != 0)
            begin
                wdist = ((dx - ONE_Q10) * 16384) / ax;
                coord = py + floor_quot((dx - ONE_Q10) * ry, ax);
            end
            else
            begin
                wdist = 65535; coord = py;
            end
        end
        else
        begin
            if (ay != 0)
            begin
                wdist = ((dy - ONE_Q10) * 16384) / ay;
                coord = px + floor_quot((dy - ONE_Q10) * rx, ay);
            end
            else
            begin
                wdist = 65535; coord = px;
            end
        end
        if (wdist > 65535)
            wdist = 65535;
        lh   = wdist == 0 ? (longint'(1) << 24) : (longint'(ROWS) * ONE_Q10) / wdist;
        half = lh >>> 1;
        s0   = clip_row(-half + ROWS / 2 + longint'($signed(cam.horizon_shift)));
        s1   = clip_row(half + ROWS / 2 + longint'($signed(cam.horizon_shift)));
        tw   = cam.texture_width;
        if (tw < 1)
            tw = 1;
        if (tw > 64)
            tw = 64;
        fr  = coord & 1023;
        tex = (fr * tw) >>> 10;
        if ((side == 0 && rx > 0) || (side == 1 && ry < 0))
            tex = tw - tex - 1;
        r.hit_status     = STATUS_HIT;
        r.hit_side       = side[0];
        r.wall_type      = map_model[my * SIDE + mx];
        r.wall_distance  = wdist[15:0];
        r.span_start     = s0[7:0];
        r.span_end       = s1[7:0];
        r.texture_column = tex[5:0];
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= MODE_WRITE;
        end
        else
        begin
            int gap;
            if (s_tvalid && s_tready)
            begin
                if (cur_word.mode == MODE_CAST)
                begin
                    column_results.push_back(cast_column(cur_word.column));
                    casts_seen++;
                end
                else
                begin
                    map_model[cur_word.cell_index] = cur_word.cell_value;
                    writes_seen++;
                end
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (gap > 0)
                begin
                    gap = gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending.size() > 0)
                begin
                    cur_word = pending.pop_front();
                    s_tdata  <= {1'b0, cur_word.cell_value, cur_word.cell_index, cur_word.column};
                    s_tuser  <= cur_word.mode;
                    s_tvalid <= 1'b1;
                    gap = $urandom_range(0, gap_max);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            int stall;
            result_t got;
            result_t want;
            if (m_tvalid && m_tready)
            begin
                got.out_column     = m_tdata[8:0];
                got.hit_status     = m_tuser;
                got.hit_side       = m_tdata[9];
                got.wall_type      = m_tdata[13:10];
                got.wall_distance  = m_tdata[29:14];
                got.span_start     = m_tdata[37:30];
                got.span_end       = m_tdata[45:38];
                got.texture_column = m_tdata[51:46];
                if (column_results.size() == 0)
                begin
                    $display("%0t unexpected word: expected none, actual %p", $time, got);
                    errors++;
                end
                else
                begin
                    want = column_results.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t mismatch: expected %p", $time, want);
                        $display("%0t           actual   %p", $time, got);
                        errors++;
                    end
                    if (want.hit_status == STATUS_NOHIT)
                        nohits_seen++;
                end
                stall = $urandom_range(0, stall_max);
            end
            else if (stall > 0)
                stall = stall - 1;
            m_tready <= (stall == 0);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_CAMERA_X:      cam.camera_x      = val[14:0];
            CFG_CAMERA_Y:      cam.camera_y      = val[14:0];
            CFG_VIEW_DIR_X:    cam.view_dir_x    = val;
            CFG_VIEW_DIR_Y:    cam.view_dir_y    = val;
            CFG_CAM_PLANE_X:   cam.cam_plane_x   = val;
            CFG_CAM_PLANE_Y:   cam.cam_plane_y   = val;
            CFG_HORIZON_SHIFT: cam.horizon_shift = val[7:0];
            CFG_TEXTURE_WIDTH: cam.texture_width = val[6:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic add_word(logic mode, logic [8:0] col, logic [9:0] idx, logic [3:0] val);
        item_t w;
        w.mode       = mode;
        w.column     = col;
        w.cell_index = idx;
        w.cell_value = val;
        pending.push_back(w);
    endtask

    task automatic wait_drained();
        while (pending.size() > 0 || s_tvalid || column_results.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_dir(int kind);
        case (kind)
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    initial
    begin
        int k;
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        gap_max   = 0;
        stall_max = 0;
        cam.camera_x      = 15'd2048;
        cam.camera_y      = 15'd2048;
        cam.view_dir_x    = -16'sd16384;
        cam.view_dir_y    = 16'sd0;
        cam.cam_plane_x   = 16'sd0;
        cam.cam_plane_y   = 16'sd10813;
        cam.horizon_shift = 8'sd0;
        cam.texture_width = 7'd32;
        foreach (map_model[i])
            map_model[i] = 4'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty map, corner cells, far column, extrapolated column
        add_word(MODE_CAST, 9'd0, '0, '0);
        add_word(MODE_CAST, 9'd399, '0, '0);
        add_word(MODE_WRITE, '0, 10'd0, 4'd15);
        add_word(MODE_WRITE, '0, 10'd1023, 4'd1);
        for (k = 0; k < SIDE; k++)
            add_word(MODE_WRITE, '0, 10'(k), 4'd9);
        add_word(MODE_WRITE, '0, 10'(2 * SIDE + 5), 4'd7);
        add_word(MODE_CAST, 9'd0, '0, '0);
        add_word(MODE_CAST, 9'd200, '0, '0);
        add_word(MODE_CAST, 9'd399, '0, '0);
        add_word(MODE_CAST, 9'd511, '0, '0);
        add_word(MODE_CAST, 9'd256, '0, '0);
        add_word(MODE_WRITE, '0, 10'(2 * SIDE + 5), 4'd0);
        add_word(MODE_CAST, 9'd100, '0, '0);
        wait_drained();

        for (int ph = 0; ph < 9; ph++)
        begin
            @(posedge clk);
            write_reg(CFG_CAMERA_X, ph == 1 ? 16'd0 : ph == 2 ? 16'h7FFF
                                    : 16'($urandom_range(1024, 31743)));
            write_reg(CFG_CAMERA_Y, ph == 1 ? 16'd0 : ph == 2 ? 16'h7FFF
                                    : 16'($urandom_range(1024, 31743)));
            write_reg(CFG_VIEW_DIR_X, ph == 3 ? 16'h0000 : pick_dir(ph == 1 ? 0 : ph == 2 ? 1 : 3));
            write_reg(CFG_VIEW_DIR_Y, ph == 3 ? 16'h0000 : pick_dir(ph == 1 ? 1 : ph == 2 ? 0 : 3));
            write_reg(CFG_CAM_PLANE_X, ph == 3 ? 16'h0000 : pick_dir(ph == 4 ? 2 : ph == 1 ? 1 : 3));
            write_reg(CFG_CAM_PLANE_Y, ph == 3 || ph == 4 ? 16'h0000 : pick_dir(ph == 2 ? 0 : 3));
            write_reg(CFG_HORIZON_SHIFT, ph == 1 ? 16'h0088 : ph == 2 ? 16'h0078 :
                      16'($signed($urandom_range(0, 240)) - 120));
            write_reg(CFG_TEXTURE_WIDTH, ph == 1 ? 16'd0 : ph == 2 ? 16'd127 :
                      ph == 5 ? 16'd64 : ph == 6 ? 16'd8 : 16'($urandom_range(0, 127)));
            cfg_we <= 1'b0;
            gap_max   = (ph % 3 == 0) ? 0 : 4;
            stall_max = (ph % 4 == 1) ? 0 : 4;
            for (k = 0; k < 198; k++)
            begin
                if ($urandom_range(0, 9) < 4)
                    add_word(MODE_WRITE, 9'($urandom_range(0, 511)), 10'($urandom_range(0, 1023)),
                             $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(1, 15)));
                else
                    add_word(MODE_CAST, $urandom_range(0, 9) == 0 ? 9'($urandom_range(400, 511))
                                                                  : 9'($urandom_range(0, 399)),
                             10'($urandom_range(0, 1023)), 4'($urandom_range(0, 15)));
            end
            wait_drained();
        end

        while (column_results.size() > 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        $display("covered %0d map writes and %0d column casts, %0d of them without a wall",
                 writes_seen, casts_seen, nohits_seen);
        $display("over nine camera settings including zero and extreme rays and clamped texture widths");
        if (errors == 0 && column_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
